// File: design/bsdc_pkg.sv
// Package: widths, command and action codes for the bypass silence drain controller.
`default_nettype none
package bsdc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 32;
  localparam int FRAME_BITS  = 16;
  localparam int BOUND_BITS  = 32;
  localparam int ENV_BITS    = 24;

  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 32;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  localparam logic [1:0] ACT_LIVE        = 2'd0;
  localparam logic [1:0] ACT_STOPPED     = 2'd1;
  localparam logic [1:0] ACT_DRAIN       = 2'd2;
  localparam logic [1:0] ACT_DRAIN_RESET = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [1:0]          action;
    logic [ENV_BITS-1:0] envelope;
    logic                envelope_new;
  } result_t;

endpackage
`default_nettype wire

// File: design/bypass_silence_drain_controller.sv
// Top level: peak tracking and bypass drain decision per audio block.
//
//  channel | dir | handshake                    | payload
//  s_      | in  | s_tvalid / s_tready          | s_tuser: cmd; s_tdata: sample, bypassed, frames
//  m_      | out | m_tvalid / m_tready          | m_tdata: action, envelope, envelope_new
//  apb     | in  | psel, penable, pwrite, pready| paddr, pwdata, prdata (silence_bound at 0)
//
// One request per cycle while s_tready is high; every request updates state in the cycle it is accepted.
// A begin-block request yields one result, held in the output register from the following cycle.
// The output register is the only stall point: a request is taken while the
// result register is empty or being drained in the same cycle.
// rst (synchronous) clears all state but the result register, and the silence bound; no clearing pass.
`default_nettype none
module bypass_silence_drain_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // [23:0] sample, [24] bypassed, [40:25] frames, [47:41] zero
  input  wire logic [47:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_tuser,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // [1:0] action, [25:2] envelope, [26] envelope_new, [31:27] zero
  output      logic [31:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic [bsdc_pkg::BOUND_BITS-1:0]  silence_bound;
  logic [bsdc_pkg::SAMPLE_BITS-1:0] peak_level, peak_level_next;
  logic [bsdc_pkg::BOUND_BITS-1:0]  active_limit, active_limit_next;
  logic                             limit_pending, limit_pending_next;
  logic [bsdc_pkg::COUNT_BITS-1:0]  elapsed_frames, elapsed_frames_next;
  logic                             is_stopped, is_stopped_next;
  logic                             was_bypassed, was_bypassed_next;
  logic [bsdc_pkg::ENV_BITS-1:0]    held_envelope, held_envelope_next;
  bsdc_pkg::result_t                result, result_next;

  logic                             in_fire, cfg_write, emit;
  logic [1:0]                       cmd;
  logic signed [bsdc_pkg::SAMPLE_BITS-1:0] sample;
  logic                             byp;
  logic [bsdc_pkg::FRAME_BITS-1:0]  frames;
  logic [bsdc_pkg::SAMPLE_BITS-1:0] mag;
  logic [bsdc_pkg::COUNT_BITS:0]    sum;

  assign cmd    = s_tuser;
  assign sample = s_tdata[23:0];
  assign byp    = s_tdata[24];
  assign frames = s_tdata[40:25];

  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : silence_bound;

  assign mag = sample[bsdc_pkg::SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  always_comb begin
    peak_level_next     = peak_level;
    active_limit_next   = active_limit;
    limit_pending_next  = limit_pending;
    elapsed_frames_next = elapsed_frames;
    is_stopped_next     = is_stopped;
    was_bypassed_next   = was_bypassed;
    held_envelope_next  = held_envelope;
    result_next         = '0;
    emit                = 1'b0;
    sum                 = '0;
    unique case (cmd)
      bsdc_pkg::CMD_SAMPLE: begin
        if (mag > peak_level) begin
          peak_level_next = mag;
        end
      end
      bsdc_pkg::CMD_RESET: begin
        peak_level_next     = '0;
        elapsed_frames_next = '0;
        was_bypassed_next   = byp;
        is_stopped_next     = byp;
      end
      bsdc_pkg::CMD_BEGIN: begin
        emit = 1'b1;
        // apply a pending bound before the bypass decision
        if (limit_pending) begin
          active_limit_next  = silence_bound;
          limit_pending_next = 1'b0;
          if (byp && !is_stopped) begin
            elapsed_frames_next = '0;
          end
        end
        if (!byp) begin
          was_bypassed_next  = 1'b0;
          is_stopped_next    = 1'b0;
          result_next.action = bsdc_pkg::ACT_LIVE;
        end else begin
          if (!was_bypassed) begin
            held_envelope_next       = peak_level;
            result_next.envelope_new = 1'b1;
            elapsed_frames_next      = '0;
            is_stopped_next          = 1'b0;
            was_bypassed_next        = 1'b1;
          end
          if (is_stopped_next) begin
            result_next.action = bsdc_pkg::ACT_STOPPED;
          end else begin
            sum = {1'b0, elapsed_frames_next} + {{(bsdc_pkg::COUNT_BITS+1-
                   bsdc_pkg::FRAME_BITS){1'b0}}, frames};
            elapsed_frames_next = sum[bsdc_pkg::COUNT_BITS] ? bsdc_pkg::COUNT_MAX
                                : sum[bsdc_pkg::COUNT_BITS-1:0];
            if (active_limit_next != '0 && elapsed_frames_next >= active_limit_next) begin
              is_stopped_next    = 1'b1;
              peak_level_next    = '0;
              result_next.action = bsdc_pkg::ACT_DRAIN_RESET;
            end else begin
              result_next.action = bsdc_pkg::ACT_DRAIN;
            end
          end
        end
        result_next.envelope = held_envelope_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_bound  <= '0;
      peak_level     <= '0;
      active_limit   <= '0;
      limit_pending  <= 1'b0;
      elapsed_frames <= '0;
      is_stopped     <= 1'b0;
      was_bypassed   <= 1'b0;
      held_envelope  <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        silence_bound <= pwdata;
        limit_pending <= 1'b1;
      end else if (in_fire) begin
        limit_pending <= limit_pending_next;
      end
      if (in_fire) begin
        peak_level     <= peak_level_next;
        active_limit   <= active_limit_next;
        elapsed_frames <= elapsed_frames_next;
        is_stopped     <= is_stopped_next;
        was_bypassed   <= was_bypassed_next;
        held_envelope  <= held_envelope_next;
      end
      if (in_fire && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      result <= result_next;
    end
  end

  assign m_tdata = {5'd0, result.envelope_new, result.envelope, result.action};

  a_stop_implies_bypass: assert property (@(posedge clk) disable iff (rst)
    is_stopped |-> was_bypassed)
    else $error("stopped without bypass");

  a_new_env_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[26]) |->
      (m_tdata[1:0] == bsdc_pkg::ACT_DRAIN || m_tdata[1:0] == bsdc_pkg::ACT_DRAIN_RESET))
    else $error("new envelope without drain");

  a_peak_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == bsdc_pkg::CMD_SAMPLE) |=> peak_level >= $past(peak_level))
    else $error("peak decreased on sample");

  a_stop_clears_peak: assert property (@(posedge clk) disable iff (rst)
    (in_fire && emit && result_next.action == bsdc_pkg::ACT_DRAIN_RESET)
      |=> (peak_level == '0 && is_stopped))
    else $error("stop did not clear peak");

endmodule
`default_nettype wire
